[rtl/lmslp_pkg.sv]
// Shared types, register codes and constants of the LMS linear predictor.
`timescale 1ns / 1ps

package lmslp_pkg;

  // Configuration port geometry
  localparam int CFG_IDX_W  = 3;
  localparam int CFG_DATA_W = 32;

  // Number of initial weight registers
  localparam int INIT_REGS = 5;

  // Reset values of the registers and of the adaptive state
  localparam logic [15:0]        LR_RESET     = 16'd655;
  localparam logic signed [31:0] BIAS_RESET   = 32'sd8388608;
  localparam logic signed [31:0] WEIGHT_RESET = 32'sd8388608;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_LEARNING_RATE    = 3'd0,
    REG_INITIAL_BIAS     = 3'd1,
    REG_INITIAL_WEIGHT_0 = 3'd2,
    REG_INITIAL_WEIGHT_1 = 3'd3,
    REG_INITIAL_WEIGHT_2 = 3'd4,
    REG_INITIAL_WEIGHT_3 = 3'd5,
    REG_INITIAL_WEIGHT_4 = 3'd6
  } cfg_reg_t;

  typedef enum logic [1:0] {
    MODE_TRAIN    = 2'd0,
    MODE_EVAL     = 2'd1,
    MODE_FORECAST = 2'd2,
    MODE_RESTART  = 2'd3
  } mode_t;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_MAC,
    ST_PRED,
    ST_ERR,
    ST_SQ,
    ST_UPD,
    ST_RESTART,
    ST_FIN
  } state_t;

  typedef struct packed {
    mode_t              mode;
    logic signed [15:0] sample;
  } in_item_t;

  typedef struct packed {
    logic signed [15:0] prediction;
    logic signed [15:0] error;
    logic [31:0]        half_sq_error;
  } out_item_t;

  typedef struct packed {
    logic [15:0]                  learning_rate;
    logic signed [31:0]           initial_bias;
    logic [INIT_REGS-1:0][31:0]   initial_weight;
  } cfg_t;

endpackage

[rtl/lmslp_stream_if.sv]
// Valid/ready stream interface carrying one payload item per transaction.
`timescale 1ns / 1ps

interface lmslp_stream_if #(parameter type T = logic);
  logic valid;
  logic ready;
  T     data;

  modport source (output valid, output data, input ready);
  modport sink   (input valid, input data, output ready);
endinterface

[rtl/lmslp_ram.sv]
// Generic single-write, single-read synchronous RAM with registered read data.
`timescale 1ns / 1ps

module lmslp_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 5
) (
  input  logic                                   clk,
  input  logic                                   we,
  input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] waddr,
  input  logic [WIDTH-1:0]                       wdata,
  input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] raddr,
  output logic [WIDTH-1:0]                       rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  // Write port
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  // Registered read port
  always_ff @(posedge clk) begin
    rdata <= mem[raddr];
  end

endmodule

[rtl/lmslp_cfg_regs.sv]
// Configuration register file: step size, initial bias and initial weights.
`timescale 1ns / 1ps

module lmslp_cfg_regs import lmslp_pkg::*; (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  wr_en,
  input  logic [CFG_IDX_W-1:0]  index,
  input  logic [CFG_DATA_W-1:0] data,
  output cfg_t                  cfg
);

  // Decode the write; indexes past the list drop the write
  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.learning_rate <= LR_RESET;
      cfg.initial_bias  <= BIAS_RESET;
      for (int k = 0; k < INIT_REGS; k++) begin
        cfg.initial_weight[k] <= WEIGHT_RESET;
      end
    end else if (wr_en) begin
      unique case (index) inside
        REG_LEARNING_RATE: cfg.learning_rate <= data[15:0];
        REG_INITIAL_BIAS:  cfg.initial_bias  <= data;
        [REG_INITIAL_WEIGHT_0:REG_INITIAL_WEIGHT_4]:
          cfg.initial_weight[index - CFG_IDX_W'(REG_INITIAL_WEIGHT_0)] <= data;
        default: ;
      endcase
    end
  end

endmodule

[rtl/lms_linear_predictor.sv]
// Top level: LMS adaptive linear predictor with weights and window held in RAM.
//
//   channel   dir   payload                               handshake
//   items     in    mode[1:0], sample[15:0]               valid/ready
//   results   out   prediction, error, half_sq_error      valid/ready
//   cfg       in    cfg_index[2:0], cfg_data[31:0]        cfg_wr_en, no wait
//
// One item is worked at a time. From acceptance to the result register a train
// item passes the states MAC, PRED, ERR, SQ, UPD and FIN; evaluate and forecast
// items skip UPD, and restart items pass RESTART and FIN. MAC and UPD are
// tap-serial passes over the weight and window RAMs: one read a cycle, one
// shared multiplier, and in train mode a second pass that writes the weights.
// Reset is synchronous; valid bits stand in for the reset contents of both
// RAMs. A new item is taken while a finished result waits; a stalled result
// holds the next item in FIN.
`timescale 1ns / 1ps

module lms_linear_predictor import lmslp_pkg::*; #(
  parameter int TAPS = 5
) (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  cfg_wr_en,
  input  logic [CFG_IDX_W-1:0]  cfg_index,
  input  logic [CFG_DATA_W-1:0] cfg_data,
  lmslp_stream_if.sink          items,
  lmslp_stream_if.source        results
);

  localparam int AW     = (TAPS > 1) ? $clog2(TAPS) : 1;
  localparam int CW     = $clog2(TAPS + 1);
  localparam int PROD_W = 49;
  localparam int ACC_W  = PROD_W + CW + 1;
  localparam int RS_W   = ACC_W - 24;

  cfg_t cfg;

  lmslp_cfg_regs u_cfg_regs (
    .clk   (clk),
    .rst   (rst),
    .wr_en (cfg_wr_en),
    .index (cfg_index),
    .data  (cfg_data),
    .cfg   (cfg)
  );

  // Weight that a tap takes after reset
  function automatic logic signed [31:0] weight_reset(input logic [AW-1:0] j);
    weight_reset = (int'(j) < INIT_REGS) ? WEIGHT_RESET : 32'sd0;
  endfunction

  // Weight that a tap takes on restart
  function automatic logic signed [31:0] weight_init(input cfg_t c, input logic [AW-1:0] j);
    weight_init = 32'sd0;
    for (int k = 0; k < INIT_REGS; k++) begin
      if (int'(j) == k) begin
        weight_init = c.initial_weight[k];
      end
    end
  endfunction

  state_t state, state_next;

  mode_t              mode_q;
  logic signed [15:0] sample_q;

  // Tap pass control
  logic [CW-1:0] issue_cnt;
  logic [AW-1:0] issue_idx;
  logic          issuing;
  logic          pass_done;
  logic          s1, s2;
  logic [AW-1:0] idx1, idx2;
  logic          wv1, xv1;

  // Window ring buffer
  logic [AW-1:0]   head;
  logic [AW:0]     x_sum;
  logic [AW-1:0]   x_phys;
  logic [TAPS-1:0] w_valid;
  logic [TAPS-1:0] x_valid;

  // RAM ports
  logic          w_we;
  logic [AW-1:0] w_waddr;
  logic [31:0]   w_wdata;
  logic [31:0]   w_rdata;
  logic          x_we;
  logic [15:0]   x_wdata;
  logic [15:0]   x_rdata;

  // Datapath
  logic signed [31:0]        w_eff, w2;
  logic signed [15:0]        x_eff;
  logic signed [32:0]        mul_a;
  logic signed [PROD_W-1:0]  prod;
  logic signed [PROD_W-1:0]  prod_rnd;
  logic signed [33:0]        w_new;
  logic signed [31:0]        w_sat;
  logic signed [ACC_W-1:0]   acc;
  logic signed [ACC_W-1:0]   acc_rnd;
  logic signed [RS_W-1:0]    rs;
  logic signed [31:0]        bias;
  logic signed [32:0]        ae_rnd;
  logic signed [33:0]        bias_new;
  logic signed [15:0]        pred, err;
  logic signed [16:0]        diff;
  logic signed [31:0]        sq;
  logic [31:0]               hsq;
  logic signed [32:0]        ae;

  logic out_free;
  logic out_load;

  assign out_free  = !results.valid || results.ready;
  assign issue_idx = issue_cnt[AW-1:0];
  assign issuing   = ((state == ST_MAC) || (state == ST_UPD)) && (issue_cnt < CW'(TAPS));
  assign pass_done = (issue_cnt == CW'(TAPS)) && !s1 && !s2;

  // Map the logical tap onto the ring position
  assign x_sum  = {1'b0, head} + {1'b0, issue_idx};
  assign x_phys = (x_sum >= (AW + 1)'(TAPS)) ? AW'(x_sum - (AW + 1)'(TAPS)) : x_sum[AW-1:0];

  lmslp_ram #(.WIDTH(32), .DEPTH(TAPS)) u_weight_ram (
    .clk   (clk),
    .we    (w_we),
    .waddr (w_waddr),
    .wdata (w_wdata),
    .raddr (issue_idx),
    .rdata (w_rdata)
  );

  lmslp_ram #(.WIDTH(16), .DEPTH(TAPS)) u_window_ram (
    .clk   (clk),
    .we    (x_we),
    .waddr (head),
    .wdata (x_wdata),
    .raddr (x_phys),
    .rdata (x_rdata)
  );

  // Next state and handshake
  always_comb begin
    state_next  = state;
    items.ready = 1'b0;
    out_load    = 1'b0;
    unique case (state)
      ST_IDLE: begin
        items.ready = 1'b1;
        if (items.valid) begin
          state_next = (items.data.mode == MODE_RESTART) ? ST_RESTART : ST_MAC;
        end
      end
      ST_MAC: begin
        if (pass_done) state_next = ST_PRED;
      end
      ST_PRED: state_next = ST_ERR;
      ST_ERR:  state_next = ST_SQ;
      ST_SQ: begin
        state_next = (mode_q == MODE_TRAIN) ? ST_UPD : ST_FIN;
      end
      ST_UPD: begin
        if (pass_done) state_next = ST_FIN;
      end
      ST_RESTART: begin
        if (issue_cnt == CW'(TAPS - 1)) state_next = ST_FIN;
      end
      ST_FIN: begin
        if (out_free) begin
          out_load   = 1'b1;
          state_next = ST_IDLE;
        end
      end
      default: state_next = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  // Hold the item while it is worked
  always_ff @(posedge clk) begin
    if (items.valid && items.ready) begin
      mode_q   <= items.data.mode;
      sample_q <= items.data.sample;
    end
  end

  // Advance the tap counter; restart it on every state change
  always_ff @(posedge clk) begin
    if (rst) begin
      issue_cnt <= '0;
      s1        <= 1'b0;
      s2        <= 1'b0;
    end else begin
      if (state_next != state) begin
        issue_cnt <= '0;
      end else if (issuing || (state == ST_RESTART)) begin
        issue_cnt <= issue_cnt + CW'(1);
      end
      s1 <= issuing;
      s2 <= s1;
    end
  end

  // Read stage: sample the valid bits with the address
  always_ff @(posedge clk) begin
    idx1 <= issue_idx;
    wv1  <= w_valid[issue_idx];
    xv1  <= x_valid[x_phys];
  end

  // Entries never written read as their reset value
  assign w_eff = wv1 ? $signed(w_rdata) : weight_reset(idx1);
  assign x_eff = xv1 ? $signed(x_rdata) : 16'sd0;

  // Shared multiplier: weight times window, or scaled error times window
  assign mul_a = (state == ST_UPD) ? ae : {w_eff[31], w_eff};

  always_ff @(posedge clk) begin
    prod <= mul_a * x_eff;
    w2   <= w_eff;
    idx2 <= idx1;
  end

  // Weight update: round the correction, subtract, saturate
  assign prod_rnd = prod + PROD_W'(32768);
  assign w_new    = {{2{w2[31]}}, w2} - {prod_rnd[PROD_W-1], prod_rnd[PROD_W-1:16]};
  assign w_sat    = (w_new > 34'sd2147483647)  ? 32'sh7FFFFFFF :
                    (w_new < -34'sd2147483648) ? 32'sh80000000 : w_new[31:0];

  always_comb begin
    if (state == ST_RESTART) begin
      w_we    = 1'b1;
      w_waddr = issue_idx;
      w_wdata = weight_init(cfg, issue_idx);
    end else begin
      w_we    = (state == ST_UPD) && s2;
      w_waddr = idx2;
      w_wdata = w_sat;
    end
  end

  // Accumulate the weighted window sum
  always_ff @(posedge clk) begin
    if (state == ST_IDLE) begin
      acc <= '0;
    end else if ((state == ST_MAC) && s2) begin
      acc <= acc + {{(ACC_W - PROD_W){prod[PROD_W-1]}}, prod};
    end
  end

  // Prediction: subtract the scaled bias, round half up, saturate
  assign acc_rnd = acc - {{(ACC_W - 44){bias[31]}}, bias, 12'd0} + ACC_W'(1 << 23);
  assign rs      = acc_rnd[ACC_W-1:24];
  assign diff    = {pred[15], pred} - {sample_q[15], sample_q};
  assign sq      = err * err;

  always_ff @(posedge clk) begin
    if (state == ST_PRED) begin
      pred <= (rs > RS_W'(32767))  ? 16'sh7FFF :
              (rs < -RS_W'(32768)) ? 16'sh8000 : rs[15:0];
    end
    if (state == ST_ERR) begin
      err <= (diff > 17'sd32767)  ? 16'sh7FFF :
             (diff < -17'sd32768) ? 16'sh8000 : diff[15:0];
    end
    if (state == ST_SQ) begin
      hsq <= {1'b0, sq[31:1]};
      ae  <= $signed({1'b0, cfg.learning_rate}) * err;
    end
  end

  // Bias update with rounded step
  assign ae_rnd   = ae + 33'sd8;
  assign bias_new = {{2{bias[31]}}, bias} + {{5{ae_rnd[32]}}, ae_rnd[32:4]};

  always_ff @(posedge clk) begin
    if (rst) begin
      bias <= BIAS_RESET;
    end else if (out_load) begin
      if (mode_q == MODE_RESTART) begin
        bias <= cfg.initial_bias;
      end else if (mode_q == MODE_TRAIN) begin
        bias <= (bias_new > 34'sd2147483647)  ? 32'sh7FFFFFFF :
                (bias_new < -34'sd2147483648) ? 32'sh80000000 : bias_new[31:0];
      end
    end
  end

  // Shift into the window: overwrite the oldest slot and advance the head
  assign x_we    = out_load && (mode_q != MODE_RESTART);
  assign x_wdata = (mode_q == MODE_FORECAST) ? pred : sample_q;

  always_ff @(posedge clk) begin
    if (rst) begin
      head    <= '0;
      x_valid <= '0;
    end else if (out_load) begin
      if (mode_q == MODE_RESTART) begin
        head    <= '0;
        x_valid <= '0;
      end else begin
        x_valid[head] <= 1'b1;
        head          <= (head == AW'(TAPS - 1)) ? '0 : head + AW'(1);
      end
    end
  end

  // Mark weights as written
  always_ff @(posedge clk) begin
    if (rst) begin
      w_valid <= '0;
    end else if (w_we) begin
      w_valid[w_waddr] <= 1'b1;
    end
  end

  // Result register
  always_ff @(posedge clk) begin
    if (rst) begin
      results.valid <= 1'b0;
    end else if (out_load) begin
      results.valid <= 1'b1;
    end else if (results.ready) begin
      results.valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (out_load) begin
      if (mode_q == MODE_RESTART) begin
        results.data <= '0;
      end else begin
        results.data.prediction    <= pred;
        results.data.error         <= err;
        results.data.half_sq_error <= hsq;
      end
    end
  end

endmodule

[rtl/lmslp_checker.sv]
// Port-level checker for the LMS linear predictor and its bind to the top level.
`timescale 1ns / 1ps

module lmslp_checker import lmslp_pkg::*; (
  input logic      clk,
  input logic      rst,
  input logic      in_valid,
  input logic      in_ready,
  input logic      out_valid,
  input logic      out_ready,
  input out_item_t out_data
);

  logic signed [31:0] err_ext;
  logic signed [31:0] err_sq;
  logic [31:0]        hsq_chk;

  // Recompute the half squared error from the error field
  assign err_ext = 32'(out_data.error);
  assign err_sq  = err_ext * err_ext;
  assign hsq_chk = {1'b0, err_sq[31:1]};

  // No result survives reset
  a_reset_clears: assert property (@(posedge clk) rst |=> !out_valid)
    else $error("result valid after reset");

  // A stalled result holds
  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_ready |=> out_valid && $stable(out_data))
    else $error("stalled result changed");

  // One item at a time: the input closes after each transaction
  a_one_item: assert property (@(posedge clk) disable iff (rst)
    in_valid && in_ready |=> !in_ready)
    else $error("input open while an item is worked");

  // The squared error matches the error field
  a_hsq_match: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> out_data.half_sq_error == hsq_chk)
    else $error("half squared error disagrees with error");

endmodule

bind lms_linear_predictor lmslp_checker u_lmslp_checker (
  .clk       (clk),
  .rst       (rst),
  .in_valid  (items.valid),
  .in_ready  (items.ready),
  .out_valid (results.valid),
  .out_ready (results.ready),
  .out_data  (results.data)
);

[bench/lmslp_result_check.sv]
// Result checker: mirrors the LMS predictor state and compares every result transaction.
`timescale 1ns / 1ps

module lmslp_result_check import lmslp_pkg::*; #(
  parameter int TAPS = 5
) (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  cfg_wr_en,
  input  logic [CFG_IDX_W-1:0]  cfg_index,
  input  logic [CFG_DATA_W-1:0] cfg_data,
  input  logic                  in_valid,
  input  logic                  in_ready,
  input  in_item_t              in_data,
  input  logic                  out_valid,
  input  logic                  out_ready,
  input  out_item_t             out_data,
  output int                    mismatches,
  output int                    outstanding
);

  localparam longint S16_MIN = -32768;
  localparam longint S16_MAX = 32767;
  localparam longint S32_MIN = -64'sd2147483648;
  localparam longint S32_MAX = 64'sd2147483647;
  localparam longint U32_MAX = 64'sd4294967295;

  // Register copies
  logic [15:0]        step_size;
  logic signed [31:0] restart_bias;
  logic signed [31:0] restart_weight [INIT_REGS];

  // Neuron state: history[0] is the oldest sample
  logic signed [15:0] history [TAPS];
  logic signed [31:0] coeff [TAPS];
  logic signed [31:0] offset;

  out_item_t pending_results [$];
  int        bad_count = 0;

  // Round half up while dividing by 2^s
  function automatic longint round_div(longint v, int s);
    return (v + (longint'(1) <<< (s - 1))) >>> s;
  endfunction

  function automatic longint clamp(longint v, longint lo, longint hi);
    return (v < lo) ? lo : ((v > hi) ? hi : v);
  endfunction

  // Reload weights and bias from the registers and clear the window
  function automatic void reload();
    for (int j = 0; j < TAPS; j++) begin
      history[j] = '0;
      coeff[j]   = (j < INIT_REGS) ? restart_weight[j] : '0;
    end
    offset = restart_bias;
  endfunction

  // Work out one result and advance the neuron state
  function automatic out_item_t neuron_step(in_item_t it);
    longint    acc;
    longint    pred;
    longint    err;
    longint    hsq;
    longint    scaled_err;
    longint    delta;
    out_item_t r;
    if (it.mode == MODE_RESTART) begin
      reload();
      return '0;
    end
    acc = 0;
    for (int j = 0; j < TAPS; j++) begin
      acc += longint'(coeff[j]) * longint'(history[j]);
    end
    acc -= longint'(offset) * 4096;
    pred = clamp(round_div(acc, 24), S16_MIN, S16_MAX);
    err  = clamp(pred - longint'(it.sample), S16_MIN, S16_MAX);
    hsq  = clamp((err * err) / 2, 0, U32_MAX);
    r.prediction    = pred[15:0];
    r.error         = err[15:0];
    r.half_sq_error = hsq[31:0];
    // Widrow-Hoff update against the window before the shift
    if (it.mode == MODE_TRAIN) begin
      scaled_err = longint'(step_size) * err;
      for (int j = 0; j < TAPS; j++) begin
        delta    = round_div(scaled_err * longint'(history[j]), 16);
        coeff[j] = 32'(clamp(longint'(coeff[j]) - delta, S32_MIN, S32_MAX));
      end
      offset = 32'(clamp(longint'(offset) + round_div(scaled_err, 4), S32_MIN, S32_MAX));
    end
    for (int j = 0; j + 1 < TAPS; j++) begin
      history[j] = history[j + 1];
    end
    history[TAPS-1] = (it.mode == MODE_FORECAST) ? pred[15:0] : it.sample;
    return r;
  endfunction

  always @(posedge clk) begin
    out_item_t want;
    if (rst) begin
      step_size    = LR_RESET;
      restart_bias = BIAS_RESET;
      for (int j = 0; j < INIT_REGS; j++) begin
        restart_weight[j] = WEIGHT_RESET;
      end
      reload();
      pending_results.delete();
    end else begin
      // Check a result transaction against the oldest expectation
      if (out_valid && out_ready) begin
        if (pending_results.size() == 0) begin
          bad_count++;
          if (bad_count <= 10) begin
            $display("%0t unexpected result: pred %0d err %0d hsq %0d", $realtime,
                     out_data.prediction, out_data.error, out_data.half_sq_error);
          end
        end else begin
          want = pending_results.pop_front();
          if (want.prediction !== out_data.prediction || want.error !== out_data.error ||
              want.half_sq_error !== out_data.half_sq_error) begin
            bad_count++;
            if (bad_count <= 10) begin
              $display("%0t mismatch: expected pred %0d err %0d hsq %0d, got pred %0d err %0d hsq %0d",
                       $realtime, want.prediction, want.error, want.half_sq_error,
                       out_data.prediction, out_data.error, out_data.half_sq_error);
            end
          end
        end
      end
      // Track register writes; unknown indexes are dropped
      if (cfg_wr_en) begin
        case (cfg_index) inside
          REG_LEARNING_RATE: step_size = cfg_data[15:0];
          REG_INITIAL_BIAS:  restart_bias = cfg_data;
          [REG_INITIAL_WEIGHT_0:REG_INITIAL_WEIGHT_4]:
            restart_weight[cfg_index - REG_INITIAL_WEIGHT_0] = cfg_data;
          default: ;
        endcase
      end
      if (in_valid && in_ready) begin
        pending_results.push_back(neuron_step(in_data));
      end
    end
    mismatches  <= bad_count;
    outstanding <= pending_results.size();
  end

endmodule

[bench/lms_linear_predictor_tb.sv]
// Testbench top: drives samples and register writes into the LMS predictor and gives the verdict.
`timescale 1ns / 1ps

module lms_linear_predictor_tb;
  import lmslp_pkg::*;

  localparam int TAPS            = 5;
  localparam int PHASES          = 6;
  localparam int ITEMS_PER_PHASE = 75;
  localparam int HOLD_CYCLES     = 400;
  localparam int DRAIN_CYCLES    = 2 * TAPS + 31;
  localparam int NUM_REGS        = INIT_REGS + 2;

  // Index with no register behind it
  localparam logic [CFG_IDX_W-1:0] REG_NONE = 3'd7;

  localparam logic signed [15:0] SAMPLE_MAX = 16'sh7FFF;
  localparam logic signed [15:0] SAMPLE_MIN = 16'sh8000;
  localparam logic [31:0]        Q24_MAX    = 32'h7FFF_FFFF;
  localparam logic [31:0]        Q24_MIN    = 32'h8000_0000;

  logic                  clk;
  logic                  rst;
  logic                  cfg_wr_en;
  logic [CFG_IDX_W-1:0]  cfg_index;
  logic [CFG_DATA_W-1:0] cfg_data;
  int                    send_gap_pct = 20;
  int                    recv_gap_pct = 45;
  logic                  hold_go = 1'b0;
  logic                  recv_hold;
  int                    mismatches;
  int                    outstanding;

  lmslp_stream_if #(.T(in_item_t))  items ();
  lmslp_stream_if #(.T(out_item_t)) results ();

  lms_linear_predictor #(.TAPS(TAPS)) dut (
    .clk       (clk),
    .rst       (rst),
    .cfg_wr_en (cfg_wr_en),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .items     (items),
    .results   (results)
  );

  lmslp_result_check #(.TAPS(TAPS)) result_check (
    .clk         (clk),
    .rst         (rst),
    .cfg_wr_en   (cfg_wr_en),
    .cfg_index   (cfg_index),
    .cfg_data    (cfg_data),
    .in_valid    (items.valid),
    .in_ready    (items.ready),
    .in_data     (items.data),
    .out_valid   (results.valid),
    .out_ready   (results.ready),
    .out_data    (results.data),
    .mismatches  (mismatches),
    .outstanding (outstanding)
  );

  initial begin
    clk = 1'b0;
    forever #2 clk = ~clk;
  end

  // Receiver: random backpressure, blocked entirely during a hold-off
  initial begin
    results.ready = 1'b0;
    forever begin
      @(posedge clk);
      results.ready <= !recv_hold && ($urandom_range(99) >= recv_gap_pct);
    end
  end

  // Long receiver hold-off so the block fills up and stalls its input
  initial begin
    recv_hold = 1'b0;
    wait (hold_go);
    @(posedge clk);
    recv_hold <= 1'b1;
    repeat (HOLD_CYCLES) @(posedge clk);
    recv_hold <= 1'b0;
  end

  initial begin
    #2_000_000;
    $display("FAILED: results differ");
    $finish;
  end

  // Offer one sample transaction after a random gap and wait for acceptance
  task automatic offer(input mode_t m, input logic signed [15:0] s);
    while ($urandom_range(99) < send_gap_pct) begin
      items.valid <= 1'b0;
      @(posedge clk);
    end
    items.valid <= 1'b1;
    items.data  <= '{mode: m, sample: s};
    @(posedge clk);
    while (!items.ready) @(posedge clk);
  endtask

  // Drop valid and wait until every expected result has come back
  task automatic settle();
    items.valid <= 1'b0;
    @(posedge clk);
    while (outstanding != 0) @(posedge clk);
  endtask

  initial begin
    logic [31:0]        reg_val [NUM_REGS];
    int                 level;
    int                 slope;
    int                 run_len;
    int                 pick;
    int                 n;
    logic signed [15:0] s16;
    mode_t              m;

    rst         = 1'b1;
    cfg_wr_en   = 1'b0;
    cfg_index   = '0;
    cfg_data    = '0;
    items.valid = 1'b0;
    items.data  = '0;
    repeat (7) @(posedge clk);
    rst <= 1'b0;

    // Directed: saturating sums and errors, every mode, restart, with reset registers
    repeat (5) offer(MODE_EVAL, SAMPLE_MAX);
    offer(MODE_EVAL, SAMPLE_MIN);
    offer(MODE_TRAIN, SAMPLE_MIN);
    offer(MODE_TRAIN, SAMPLE_MAX);
    offer(MODE_FORECAST, 16'sh0000);
    offer(MODE_FORECAST, 16'shFFFF);
    offer(MODE_RESTART, 16'sh0000);
    repeat (5) offer(MODE_TRAIN, SAMPLE_MIN);
    offer(MODE_FORECAST, SAMPLE_MAX);
    offer(MODE_EVAL, 16'sh0000);
    offer(MODE_RESTART, 16'shFFFF);
    offer(MODE_TRAIN, 16'sh0001);
    offer(MODE_EVAL, 16'sh0800);

    for (int p = 0; p < PHASES; p++) begin
      settle();

      // Pick the register setting of this phase
      case (p)
        0: begin
          reg_val[0] = 32'h0000_FFFF;
          reg_val[1] = Q24_MIN;
          for (int j = 2; j < NUM_REGS; j++) reg_val[j] = Q24_MAX;
        end
        1: begin
          reg_val[0] = 32'h0000_0000;
          reg_val[1] = Q24_MAX;
          for (int j = 2; j < NUM_REGS; j++) reg_val[j] = Q24_MIN;
        end
        3: begin
          for (int j = 0; j < NUM_REGS; j++) reg_val[j] = $urandom;
        end
        5: begin
          reg_val[0] = 32'(LR_RESET);
          reg_val[1] = BIAS_RESET;
          for (int j = 2; j < NUM_REGS; j++) reg_val[j] = WEIGHT_RESET;
        end
        default: begin
          // Moderate: step size up to 0.06, bias and weights within +-1.0
          reg_val[0] = $urandom_range(4000, 100);
          for (int j = 1; j < NUM_REGS; j++) begin
            reg_val[j] = $urandom_range(32'h0200_0000) - 32'h0100_0000;
          end
        end
      endcase

      for (int r = 0; r < NUM_REGS; r++) begin
        cfg_wr_en <= 1'b1;
        cfg_index <= CFG_IDX_W'(REG_LEARNING_RATE + r);
        cfg_data  <= reg_val[r];
        @(posedge clk);
      end
      if (p == 3) begin
        cfg_index <= REG_NONE;
        cfg_data  <= $urandom;
        @(posedge clk);
      end
      cfg_wr_en <= 1'b0;

      send_gap_pct = (p < 2) ? 20 : ((p < 4) ? 45 : 0);
      recv_gap_pct = (p < 2) ? 45 : ((p < 4) ? 20 : 0);
      if (p == 1) hold_go <= 1'b1;

      // Load the new weights and bias
      offer(MODE_RESTART, 16'($urandom));

      n = 0;
      while (n < ITEMS_PER_PHASE) begin
        pick = $urandom_range(99);
        if (pick < 70) begin
          // Smooth series, mostly trained on, with some evaluate and forecast
          level   = $urandom_range(8191) - 4096;
          slope   = $urandom_range(256) - 128;
          run_len = $urandom_range(16, 6);
          for (int k = 0; k < run_len && n < ITEMS_PER_PHASE; k++) begin
            level = level + slope + $urandom_range(63) - 32;
            if (level > 32767) level = 32767;
            if (level < -32768) level = -32768;
            s16 = level[15:0];
            pick = $urandom_range(99);
            m = (pick < 80) ? MODE_TRAIN : ((pick < 90) ? MODE_EVAL : MODE_FORECAST);
            offer(m, s16);
            n++;
          end
        end else if (pick < 78) begin
          offer(MODE_RESTART, 16'($urandom));
          n++;
        end else begin
          // Noise: any mode, any sample
          s16 = 16'($urandom);
          m   = mode_t'($urandom_range(3));
          offer(m, s16);
          n++;
        end
      end
    end

    settle();
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (mismatches == 0 && outstanding == 0) begin
      $display("PASSED: all results match");
    end else begin
      $display("FAILED: results differ");
    end
    $finish;
  end

endmodule
